[src/view_pyramid_face_classifier_top_assert.svh]
// ----------------------------------------------------------------------------
// View pyramid face classifier assertion macros
// Concurrent check macros used at the end of the top level. Defining
// ASSERT_OFF leaves the macros empty.
// ----------------------------------------------------------------------------
`ifndef VIEW_PYRAMID_FACE_CLASSIFIER_TOP_ASSERT_SVH
`define VIEW_PYRAMID_FACE_CLASSIFIER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Implication checked at every rising edge outside reset.
`define VPFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vpfc: implication check failed");
// Next-cycle implication checked at every rising edge outside reset.
`define VPFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vpfc: next-cycle check failed");
`else
`define VPFC_ASSERT_IMP(lbl, ante, cons)
`define VPFC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[src/vpfc_pkg.sv]
// ----------------------------------------------------------------------------
// View pyramid face classifier package
// Item types, class codes, plane indices and register reset value.
// ----------------------------------------------------------------------------
`default_nettype none

package vpfc_pkg;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned TAN_W    = 24;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned PROD_W   = TAN_W + COORD_W;
  localparam int unsigned PLANES   = 4;

  localparam logic [TAN_W-1:0] TAN_RESET = 24'd65536;

  // Plane indices in the accumulator flag vectors.
  localparam int unsigned PLANE_POS_X = 0;
  localparam int unsigned PLANE_NEG_X = 1;
  localparam int unsigned PLANE_POS_Y = 2;
  localparam int unsigned PLANE_NEG_Y = 3;

  typedef enum logic [1:0] {
    CLS_INSIDE   = 2'd0,
    CLS_STRADDLE = 2'd1,
    CLS_OUTSIDE  = 2'd2
  } face_class_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_pos;
    logic signed [COORD_W-1:0] y_pos;
    logic signed [COORD_W-1:0] z_pos;
    logic                      last_vertex;
  } in_t;

  typedef struct packed {
    logic        any_in_front;
    face_class_t pos_x_class;
    face_class_t neg_x_class;
    face_class_t pos_y_class;
    face_class_t neg_y_class;
  } out_t;

  // Class of one plane from its accumulated outside and inside flags.
  function automatic face_class_t class_of(input logic outside_flag,
                                           input logic inside_flag);
    face_class_t c;
    if (outside_flag && inside_flag) begin
      c = CLS_STRADDLE;
    end else if (!inside_flag) begin
      c = CLS_OUTSIDE;
    end else begin
      c = CLS_INSIDE;
    end
    return c;
  endfunction

  // Magnitude of a signed coordinate; the most negative value maps to 2^31.
  function automatic logic [COORD_W-1:0] mag_of(input logic signed [COORD_W-1:0] v);
    logic [COORD_W-1:0] m;
    if (v[COORD_W-1]) begin
      m = COORD_W'(-v);
    end else begin
      m = COORD_W'(v);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[src/view_pyramid_face_classifier_top.sv]
// ----------------------------------------------------------------------------
// View pyramid face classifier
// Classifies a face, given as a stream of eye-space vertices, against the
// four side planes of a viewing pyramid looking along negative z.
//
//   channel  | handshake          | payload        | direction
//   ---------+--------------------+----------------+----------
//   vertex   | in_valid/in_stall  | in_data (in_t) | in
//   result   | out_valid/out_stall| out_data(out_t)| out
//   config   | cfg_we             | cfg_data       | in
//
// One vertex is accepted per cycle while in_stall is low. The last
// vertex of a face passes the input register, then the 24x32 multiply
// of tan_half_view by |z|, then the compare and accumulate, which loads
// its result into the output register. Only last vertices need the
// output register, so other vertices keep flowing while a result waits.
// Reset clears pipeline valid bits and accumulators and sets tan_half_view to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

`include "view_pyramid_face_classifier_top_assert.svh"

module view_pyramid_face_classifier_top
  import vpfc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_t              in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_t                  out_data,
  input  wire logic             cfg_we,
  input  wire logic [TAN_W-1:0] cfg_data
);

  // Configuration register.
  logic [TAN_W-1:0] tan_half_view;

  // Input stage.
  logic a_valid;
  in_t  a_item;

  // Product stage.
  logic                b_valid;
  logic [COORD_W-1:0]  b_x_mag;
  logic [COORD_W-1:0]  b_y_mag;
  logic                b_x_pos;
  logic                b_x_neg;
  logic                b_y_pos;
  logic                b_y_neg;
  logic                b_z_neg;
  logic                b_z_zero;
  logic [PROD_W-1:0]   b_lim;
  logic                b_last;

  // Accumulators.
  logic [PLANES-1:0] seen_outside;
  logic [PLANES-1:0] seen_inside;
  logic              front_seen;
  logic [PLANES-1:0] seen_outside_next;
  logic [PLANES-1:0] seen_inside_next;
  logic              front_seen_next;

  // Flow control.
  logic c_go;
  logic b_load;
  logic a_load;

  // Compare stage signals.
  logic [PROD_W-1:0] ax;
  logic [PROD_W-1:0] ay;
  logic              x_gt;
  logic              x_ge;
  logic              y_gt;
  logic [PLANES-1:0] outside;
  out_t              result_next;

  // Stage handshakes: a vertex leaves the product stage unless it closes a
  // face and the output register is holding a result that is stalled.
  assign c_go     = b_valid && (!b_last || !out_valid || !out_stall);
  assign b_load   = a_valid && (!b_valid || c_go);
  assign a_load   = in_valid && !in_stall;
  assign in_stall = a_valid && !b_load;

  // Configuration write.
  always_ff @(posedge clk) begin
    if (rst) begin
      tan_half_view <= TAN_RESET;
    end else if (cfg_we) begin
      tan_half_view <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_load) begin
      a_valid <= 1'b1;
    end else if (b_load) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_item <= in_data;
    end
  end

  // Product stage: magnitudes, signs and the limit tan_half_view * |z|.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_load) begin
      b_valid <= 1'b1;
    end else if (c_go) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_x_mag  <= mag_of(a_item.x_pos);
      b_y_mag  <= mag_of(a_item.y_pos);
      b_x_neg  <= a_item.x_pos[COORD_W-1];
      b_x_pos  <= !a_item.x_pos[COORD_W-1] && (a_item.x_pos != '0);
      b_y_neg  <= a_item.y_pos[COORD_W-1];
      b_y_pos  <= !a_item.y_pos[COORD_W-1] && (a_item.y_pos != '0);
      b_z_neg  <= a_item.z_pos[COORD_W-1];
      b_z_zero <= (a_item.z_pos == '0);
      b_lim    <= PROD_W'(tan_half_view) * PROD_W'(mag_of(a_item.z_pos));
      b_last   <= a_item.last_vertex;
    end
  end

  // Compare |x| and |y|, scaled to the product's fraction, with the limit.
  assign ax   = {{(PROD_W-COORD_W-FRAC_W){1'b0}}, b_x_mag, {FRAC_W{1'b0}}};
  assign ay   = {{(PROD_W-COORD_W-FRAC_W){1'b0}}, b_y_mag, {FRAC_W{1'b0}}};
  assign x_gt = (ax > b_lim);
  assign x_ge = (ax >= b_lim);
  assign y_gt = (ay > b_lim);

  // Per-plane outside tests; each plane treats the sign of z in its own way.
  always_comb begin
    if (b_z_neg) begin
      outside[PLANE_POS_X] = x_gt && b_x_pos;
      outside[PLANE_NEG_X] = x_gt && b_x_neg;
      outside[PLANE_POS_Y] = y_gt && b_y_pos;
      outside[PLANE_NEG_Y] = y_gt && b_y_neg;
    end else if (b_z_zero) begin
      outside[PLANE_POS_X] = b_x_pos;
      outside[PLANE_NEG_X] = b_x_neg;
      outside[PLANE_POS_Y] = b_y_pos;
      outside[PLANE_NEG_Y] = 1'b1;
    end else begin
      outside[PLANE_POS_X] = !(x_ge && b_x_neg);
      outside[PLANE_NEG_X] = 1'b1;
      outside[PLANE_POS_Y] = b_y_pos;
      outside[PLANE_NEG_Y] = 1'b1;
    end
  end

  // Accumulate the flags of the face, including the current vertex.
  assign seen_outside_next = seen_outside | outside;
  assign seen_inside_next  = seen_inside | ~outside;
  assign front_seen_next   = front_seen | b_z_neg;

  always_comb begin
    result_next.any_in_front = front_seen_next;
    result_next.pos_x_class  = class_of(seen_outside_next[PLANE_POS_X],
                                        seen_inside_next[PLANE_POS_X]);
    result_next.neg_x_class  = class_of(seen_outside_next[PLANE_NEG_X],
                                        seen_inside_next[PLANE_NEG_X]);
    result_next.pos_y_class  = class_of(seen_outside_next[PLANE_POS_Y],
                                        seen_inside_next[PLANE_POS_Y]);
    result_next.neg_y_class  = class_of(seen_outside_next[PLANE_NEG_Y],
                                        seen_inside_next[PLANE_NEG_Y]);
  end

  // Accumulators clear once the last vertex of a face has been classified.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_outside <= '0;
      seen_inside  <= '0;
      front_seen   <= 1'b0;
    end else if (c_go) begin
      if (b_last) begin
        seen_outside <= '0;
        seen_inside  <= '0;
        front_seen   <= 1'b0;
      end else begin
        seen_outside <= seen_outside_next;
        seen_inside  <= seen_inside_next;
        front_seen   <= front_seen_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c_go && b_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_go && b_last) begin
      out_data <= result_next;
    end
  end

  // A held, stalled result is never overwritten.
  `VPFC_ASSERT_IMP(a_no_overwrite, out_valid && out_stall, !(c_go && b_last))
  // Closing a face leaves the accumulators clear.
  `VPFC_ASSERT_NEXT(a_acc_clear, c_go && b_last,
                    (seen_outside == '0) && (seen_inside == '0) && !front_seen)
  // Every plane is marked inside or outside after an inner vertex.
  `VPFC_ASSERT_NEXT(a_acc_cover, c_go && !b_last, (seen_outside | seen_inside) == 4'hF)
  // The input register only refills when its vertex moves on or it is empty.
  `VPFC_ASSERT_IMP(a_input_hold, a_valid && !b_load, in_stall)

endmodule

`default_nettype wire

[verif/view_pyramid_face_classifier_checker.sv]
// ----------------------------------------------------------------------------
// View pyramid face classifier scoreboard
// Watches the vertex, result and register channels of the classifier. It
// keeps its own copy of the view tangent and of the per-face flags, predicts
// the class of each finished face and compares every result, field by field,
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module view_pyramid_face_classifier_checker
  import vpfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_t              in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_t             out_data,
  input  logic             cfg_we,
  input  logic [TAN_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the view tangent and of the per-face flags.
  logic [TAN_W-1:0] view_tan;
  logic [PLANES-1:0] outside_seen;
  logic [PLANES-1:0] inside_seen;
  logic front_hit;

  // Face classes predicted but not yet seen on the result channel.
  out_t face_classes_q[$];

  function automatic logic [COORD_W-1:0] magnitude(input logic signed [COORD_W-1:0] v);
    return v[COORD_W-1] ? -v : v;
  endfunction

  function automatic face_class_t plane_class(input int unsigned p);
    face_class_t c;
    if (outside_seen[p] && inside_seen[p]) begin
      c = CLS_STRADDLE;
    end else if (!inside_seen[p]) begin
      c = CLS_OUTSIDE;
    end else begin
      c = CLS_INSIDE;
    end
    return c;
  endfunction

  // Folds one vertex into the face flags; a last vertex closes the face.
  function automatic void absorb_vertex(input in_t v);
    logic signed [COORD_W-1:0] xs, ys, zs;
    logic [63:0] ax, ay, bound;
    logic [PLANES-1:0] outside;
    out_t face;
    xs = v.x_pos;
    ys = v.y_pos;
    zs = v.z_pos;
    // Both sides of the compare carry 32 fraction bits, so it is exact.
    ax = {16'b0, magnitude(xs), 16'b0};
    ay = {16'b0, magnitude(ys), 16'b0};
    bound = {40'b0, view_tan} * {32'b0, magnitude(zs)};
    if (zs < 0) begin
      outside[PLANE_POS_X] = (ax > bound) && (xs > 0);
      outside[PLANE_NEG_X] = (ax > bound) && (xs < 0);
      outside[PLANE_POS_Y] = (ay > bound) && (ys > 0);
      outside[PLANE_NEG_Y] = (ay > bound) && (ys < 0);
      front_hit = 1'b1;
    end else if (zs == 0) begin
      outside[PLANE_POS_X] = xs > 0;
      outside[PLANE_NEG_X] = xs < 0;
      outside[PLANE_POS_Y] = ys > 0;
      outside[PLANE_NEG_Y] = 1'b1;
    end else begin
      // Behind the eye the planes keep their own lopsided rules.
      outside[PLANE_POS_X] = !((ax >= bound) && (xs < 0));
      outside[PLANE_NEG_X] = 1'b1;
      outside[PLANE_POS_Y] = ys > 0;
      outside[PLANE_NEG_Y] = 1'b1;
    end
    outside_seen = outside_seen | outside;
    inside_seen = inside_seen | ~outside;
    if (v.last_vertex) begin
      face.any_in_front = front_hit;
      face.pos_x_class = plane_class(PLANE_POS_X);
      face.neg_x_class = plane_class(PLANE_NEG_X);
      face.pos_y_class = plane_class(PLANE_POS_Y);
      face.neg_y_class = plane_class(PLANE_NEG_Y);
      face_classes_q.push_back(face);
      outside_seen = '0;
      inside_seen = '0;
      front_hit = 1'b0;
    end
  endfunction

  function automatic void note_failure();
    fail_count++;
  endfunction

  // All channels are sampled at the rising edge, before the drivers update.
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      view_tan = TAN_RESET;
      outside_seen = '0;
      inside_seen = '0;
      front_hit = 1'b0;
      face_classes_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        view_tan = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (face_classes_q.size() == 0) begin
          note_failure();
          if (fail_count <= 10) begin
            $display("%0t: face result with no face pending: front=%0d classes=%0d/%0d/%0d/%0d",
                     $realtime, out_data.any_in_front, out_data.pos_x_class,
                     out_data.neg_x_class, out_data.pos_y_class, out_data.neg_y_class);
          end
        end else begin
          want = face_classes_q.pop_front();
          if ((out_data.any_in_front !== want.any_in_front) ||
              (out_data.pos_x_class !== want.pos_x_class) ||
              (out_data.neg_x_class !== want.neg_x_class) ||
              (out_data.pos_y_class !== want.pos_y_class) ||
              (out_data.neg_y_class !== want.neg_y_class)) begin
            note_failure();
            if (fail_count <= 10) begin
              $display("%0t: face result wrong: expected front=%0d classes=%0d/%0d/%0d/%0d",
                       $realtime, want.any_in_front, want.pos_x_class, want.neg_x_class,
                       want.pos_y_class, want.neg_y_class);
              $display("    got front=%0d classes=%0d/%0d/%0d/%0d",
                       out_data.any_in_front, out_data.pos_x_class, out_data.neg_x_class,
                       out_data.pos_y_class, out_data.neg_y_class);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        absorb_vertex(in_data);
      end
    end
    pending = face_classes_q.size();
  end

endmodule

[verif/view_pyramid_face_classifier_top_test.sv]
// ----------------------------------------------------------------------------
// View pyramid face classifier testbench
// Drives faces of eye-space vertices into the classifier under several view
// tangents, with random gaps on the vertex side and random stalls on the
// result side, and leaves all checking to the scoreboard beside the block.
// ----------------------------------------------------------------------------
module view_pyramid_face_classifier_top_test
  import vpfc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [COORD_W-1:0] ONE = 32'sh0001_0000;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 250;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_we;
  logic [TAN_W-1:0] cfg_data;
  int fail_count;
  int pending;

  // Flags shared between the vertex and result sides, and the current tangent.
  bit quiet;
  bit hold_req;
  logic [TAN_W-1:0] cur_tan;

  view_pyramid_face_classifier_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  view_pyramid_face_classifier_checker face_scoreboard (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic in_t pack_vertex(input logic signed [COORD_W-1:0] x,
                                      input logic signed [COORD_W-1:0] y,
                                      input logic signed [COORD_W-1:0] z,
                                      input logic last);
    in_t v;
    v.x_pos = x;
    v.y_pos = y;
    v.z_pos = z;
    v.last_vertex = last;
    return v;
  endfunction

  // Coordinate close to the plane through a point at depth mz, either side.
  function automatic logic [COORD_W-1:0] edge_coord(input logic [TAN_W-1:0] t,
                                                    input logic [COORD_W-1:0] mz);
    logic [63:0] m;
    m = ({40'b0, t} * {32'b0, mz}) >> 16;
    m = m + $urandom_range(0, 4);
    m = (m < 2) ? 64'd0 : m - 2;
    return $urandom_range(0, 1) ? -m[COORD_W-1:0] : m[COORD_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] small_coord();
    logic [COORD_W-1:0] m;
    m = $urandom_range(0, 8 * 65536);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  // Random vertex: raw bits, small coordinates, or points near the planes.
  function automatic in_t make_vertex(input logic [TAN_W-1:0] t, input logic last);
    in_t v;
    logic [63:0] cap;
    logic [COORD_W-1:0] mz;
    int mode;
    mode = $urandom_range(0, 9);
    v.last_vertex = last;
    if (mode < 3) begin
      v.x_pos = $urandom();
      v.y_pos = $urandom();
      v.z_pos = $urandom();
    end else if (mode < 5) begin
      v.x_pos = small_coord();
      v.y_pos = small_coord();
      v.z_pos = ($urandom_range(0, 7) == 0) ? '0 : small_coord();
    end else begin
      // Keep the edge coordinate inside 31 bits of magnitude.
      cap = (t == 0) ? 64'h8000_0000 : ((64'd2147483640 << 16) / t);
      if (cap > 64'h8000_0000) begin
        cap = 64'h8000_0000;
      end
      case ($urandom_range(0, 7)) inside
        0: mz = '0;
        [1:2]: mz = $urandom_range(0, 32767) << 16;
        default: mz = $urandom();
      endcase
      if (mz > cap) begin
        mz = cap[COORD_W-1:0];
      end
      if ($urandom_range(0, 9) < 7) begin
        v.z_pos = -mz;
      end else begin
        v.z_pos = mz[COORD_W-1] ? C_MAX : mz;
      end
      v.x_pos = edge_coord(t, mz);
      v.y_pos = edge_coord(t, mz);
    end
    return v;
  endfunction

  // Offers one item after a random gap and returns at the edge that takes it.
  task automatic offer_vertex(input in_t v);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // Drains the block, lets the pipeline empty, then loads a new tangent.
  task automatic load_tangent(input logic [TAN_W-1:0] t);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= t;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_tan = t;
  endtask

  // Result side: random stalls, plus one long hold-off when asked.
  initial begin
    int n;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        n = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        n = quiet ? 0 : $urandom_range(0, 11);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus.
  initial begin
    int len;
    int sent;
    logic [TAN_W-1:0] t;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    cur_tan = TAN_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset tangent of one: single-vertex faces, straddles, exact boundaries.
    offer_vertex(pack_vertex(0, 0, 0, 1'b1));
    offer_vertex(pack_vertex(ONE, ONE, -2 * ONE, 1'b1));
    offer_vertex(pack_vertex(3 * ONE, -3 * ONE, -ONE, 1'b0));
    offer_vertex(pack_vertex(0, 0, -ONE, 1'b1));
    offer_vertex(pack_vertex(ONE, ONE, -ONE, 1'b1));
    offer_vertex(pack_vertex(ONE + 1, -(ONE + 1), -ONE, 1'b1));
    offer_vertex(pack_vertex(-ONE, 5, ONE, 1'b1));
    offer_vertex(pack_vertex(-(ONE - 1), -5, ONE, 1'b1));
    offer_vertex(pack_vertex(-1, -1, 0, 1'b1));
    // Extreme coordinates, mixed over one face.
    offer_vertex(pack_vertex(C_MIN, C_MAX, C_MIN, 1'b0));
    offer_vertex(pack_vertex(C_MAX, C_MIN, C_MAX, 1'b0));
    offer_vertex(pack_vertex(C_MIN, C_MIN, C_MAX, 1'b1));
    offer_vertex(pack_vertex(C_MAX, C_MAX, -1, 1'b1));

    // Zero tangent: the pyramid closes to the axis.
    load_tangent('0);
    offer_vertex(pack_vertex(0, 0, -ONE, 1'b1));
    offer_vertex(pack_vertex(1, -1, -ONE, 1'b1));
    offer_vertex(pack_vertex(-1, 0, ONE, 1'b1));

    // Largest tangent.
    load_tangent('1);
    offer_vertex(pack_vertex(C_MAX, C_MIN, C_MIN, 1'b1));
    offer_vertex(pack_vertex(-1, 1, -1, 1'b1));
    offer_vertex(pack_vertex(C_MIN, C_MAX, -1, 1'b0));
    offer_vertex(pack_vertex(C_MAX, C_MAX, 1, 1'b1));

    // Random faces, one tangent per phase.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: t = TAN_RESET;
        1: t = 24'd1;
        3: t = '1;
        4: t = TAN_W'($urandom_range(0, 24'h01_ffff));
        6: t = '0;
        default: t = TAN_W'($urandom_range(0, 24'hff_ffff));
      endcase
      load_tangent(t);
      // One phase runs with the result side held off for a long stretch.
      if (ph == 2) begin
        hold_req = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 15) == 0) begin
          quiet = !quiet;
        end
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          offer_vertex(make_vertex(cur_tan, i == len - 1));
        end
        sent += len;
      end
    end

    // Let the last results come out, then idle before the report.
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
